// File: hw/rtl/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared constants, note table, types and the divide-by-4095 helper for the
// wavetable cutoff and pitch control block.
// ----------------------------------------------------------------------------
`default_nettype none

package wcp_pkg;

    // sizing
    localparam int TABLE_LEN   = 64;
    localparam int WAVE_COUNT  = 4;
    localparam int STORE_DEPTH = WAVE_COUNT * TABLE_LEN;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CTRL_DEPTH  = 2;

    // divider widths: quotient as wide as the period field, divisor holds bent*TABLE_LEN
    localparam int DVD_W = 25;
    localparam int DVS_W = 13 + $clog2(TABLE_LEN + 1);
    localparam int CNT_W = $clog2(DVD_W + 1);

    // arithmetic constants
    localparam logic [11:0] ADC_FULL   = 12'd4095;
    localparam logic [11:0] PITCH_MID  = 12'd2048;
    localparam int          BEND_DIV   = 8195;
    localparam logic [24:0] CLOCK_HZ   = 25'd25000000;
    localparam logic [11:0] CUTOFF_MIN = 12'd5;
    localparam logic [11:0] GAIN_RESET = 12'd1000;
    localparam logic [3:0]  KEY_MAX    = 4'd12;

    // rounded-up reciprocal of the bend divisor, exact floor for products below 2^23
    localparam int          BEND_SHIFT = 36;
    localparam logic [22:0] BEND_RECIP =
        23'(((64'd1 << BEND_SHIFT) + 64'(BEND_DIV - 1)) / 64'(BEND_DIV));

    // request modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_CUTOFF = 2'd1;
    localparam logic [1:0] MODE_PITCH  = 2'd2;

    // result kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_GAIN = 1'b0;

    // control store entries
    localparam logic CTRL_CUTOFF = 1'b0;
    localparam logic CTRL_PITCH  = 1'b1;

    // note frequencies in hertz, row per octave
    localparam logic [11:0] NOTE_HZ [8][13] = '{
        '{12'd16, 12'd17, 12'd18, 12'd19, 12'd21, 12'd22, 12'd23, 12'd24, 12'd26,
          12'd27, 12'd29, 12'd31, 12'd33},
        '{12'd33, 12'd35, 12'd37, 12'd39, 12'd41, 12'd44, 12'd46, 12'd49, 12'd52,
          12'd55, 12'd58, 12'd62, 12'd65},
        '{12'd65, 12'd69, 12'd73, 12'd78, 12'd82, 12'd87, 12'd92, 12'd98, 12'd104,
          12'd110, 12'd117, 12'd123, 12'd131},
        '{12'd131, 12'd139, 12'd147, 12'd156, 12'd167, 12'd175, 12'd185, 12'd196,
          12'd208, 12'd220, 12'd233, 12'd247, 12'd262},
        '{12'd262, 12'd277, 12'd294, 12'd311, 12'd330, 12'd349, 12'd370, 12'd392,
          12'd415, 12'd440, 12'd466, 12'd494, 12'd523},
        '{12'd523, 12'd554, 12'd587, 12'd622, 12'd659, 12'd698, 12'd740, 12'd784,
          12'd831, 12'd880, 12'd932, 12'd988, 12'd1046},
        '{12'd1046, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397, 12'd1480,
          12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976, 12'd2093},
        '{12'd2093, 12'd2218, 12'd2349, 12'd2489, 12'd2637, 12'd2794, 12'd2960,
          12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3900, 12'd3900}
    };

    // operands for the two-lane multiply and scale unit
    typedef struct packed {
        logic        load;
        logic [15:0] a0;
        logic [11:0] b0;
        logic [15:0] a1;
        logic [11:0] b1;
    } mac_ops_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // floor(v / 4095): series estimate of v/4096*(1+1/4096+...), then one correction
    function automatic logic [15:0] div4095(input logic [27:0] v);
        logic [28:0] acc;
        logic [16:0] est;
        logic [28:0] rem;
        acc = {1'b0, v} + 29'(v >> 12) + 29'(v >> 24);
        est = acc[28:12];
        rem = {1'b0, v} - {est, 12'b0} + 29'(est);
        if (rem >= 29'(ADC_FULL)) begin
            est = est + 17'd1;
        end
        return est[15:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wcp_ram.sv
// ----------------------------------------------------------------------------
// wcp_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/wcp_mac.sv
// ----------------------------------------------------------------------------
// wcp_mac
// Two-lane multiply and scale: a0*b0/4095 + a1*b1/4095, each quotient
// truncated. Products registered, then the scaled sum registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_mac
    import wcp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mac_ops_t ops,
    output logic [16:0]   sum
);

    logic [27:0] prod0_reg;
    logic [27:0] prod1_reg;
    logic        load_d_reg;
    logic [16:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_d_reg <= 1'b0;
        end else begin
            load_d_reg <= ops.load;
        end
    end

    always_ff @(posedge aclk) begin
        if (ops.load) begin
            prod0_reg <= ops.a0 * ops.b0;
            prod1_reg <= ops.a1 * ops.b1;
        end
        // sum holds until the next operand set has passed the products stage
        if (load_d_reg) begin
            sum_reg <= 17'(div4095(prod0_reg)) + 17'(div4095(prod1_reg));
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// File: hw/rtl/wcp_div.sv
// ----------------------------------------------------------------------------
// wcp_div
// Restoring unsigned divider, one quotient bit per cycle. Used for the
// sample period calculation.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_div
    import wcp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_status_t           status,
    output logic      [DVD_W-1:0] quotient
);

    logic [CNT_W-1:0] count_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] diff;

    assign shifted = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (count_reg == CNT_W'(1));
            if (start) begin
                count_reg <= CNT_W'(DVD_W);
            end else if (count_reg != '0) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (count_reg != '0) begin
            // borrow set: trial subtract failed, keep the shifted remainder
            if (diff[DVS_W+1]) begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end else begin
                rem_reg <= diff[DVS_W:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end
        end
    end

    assign status.busy = (count_reg != '0);
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

// File: hw/rtl/wavetable_cutoff_and_pitch_control_top.sv
// ----------------------------------------------------------------------------
// wavetable_cutoff_and_pitch_control_top
// Wavetable store with smoothed cutoff and pitch controls, table lowpass and
// pitch-bent sample period output.
// ----------------------------------------------------------------------------
// A load request (mode 0) writes one sample into the wave store RAM when it
// is accepted. Cutoff and pitch readings are smoothed in a two-entry
// control RAM (read, scale, write back). A cutoff request above the
// threshold then filters the selected table entry by entry, the loop
// through the multiply and scale-by-4095 unit that feeds each filtered
// value back into the next. A pitch request with a key held makes one pass
// through the bit-serial divider for the sample period; the bend scale is
// a reciprocal multiply. Requests are taken one at a time; a finished
// result waits in the output register while the next request is
// accepted. There is no clearing pass after reset; samples must be loaded
// before a table is filtered.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_cutoff_and_pitch_control_top
    import wcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [15:0] s_sample_value,
    input  wire logic [2:0]  s_wave_select,
    input  wire logic [5:0]  s_table_position,
    input  wire logic [2:0]  s_octave,
    input  wire logic [3:0]  s_key_number,
    input  wire logic        s_key_held,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic      [5:0]  m_entry_index,
    output logic      [15:0] m_filtered_sample,
    output logic      [12:0] m_bent_frequency,
    output logic      [24:0] m_period_timeout,
    output logic             m_last_of_run
);

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_SM_OPS     = 13'b0000000000010,
        S_SM_WAIT    = 13'b0000000000100,
        S_SM_DONE    = 13'b0000000001000,
        S_F_OPS      = 13'b0000000010000,
        S_F_WAIT     = 13'b0000000100000,
        S_F_SUM      = 13'b0000001000000,
        S_BEND_MUL   = 13'b0000010000000,
        S_BEND_SCALE = 13'b0000100000000,
        S_BEND_ADD   = 13'b0001000000000,
        S_PER_START  = 13'b0010000000000,
        S_PER_DIV    = 13'b0100000000000,
        S_EMIT       = 13'b1000000000000
    } state_t;

    function automatic logic [STORE_AW-1:0] store_addr(input logic [2:0] wsel,
                                                       input logic [5:0] idx);
        int a;
        a = int'(wsel) * TABLE_LEN + int'(idx);
        return STORE_AW'(a);
    endfunction

    state_t state_reg, state_next;

    logic        s_accept;
    logic        slot_free;
    logic        cfg_write;

    // latched request
    logic [1:0]  mode_reg;
    logic [15:0] sval_reg;
    logic [2:0]  wsel_reg;
    logic [2:0]  oct_reg;
    logic [3:0]  key_reg;
    logic        held_reg;

    logic [11:0] gain_reg;

    // control store
    logic [1:0]  ctrl_valid_reg;
    logic        ctrl_sel;
    logic        ctrl_raddr;
    logic        ctrl_we;
    logic [11:0] ctrl_rdata;
    logic [11:0] ctrl_prev;

    // wave store
    logic                wave_we;
    logic [STORE_AW-1:0] wave_waddr;
    logic [STORE_AW-1:0] wave_raddr;
    logic [15:0]         wave_rdata;
    logic [5:0]          rd_idx;

    // multiply and scale unit
    mac_ops_t    mac_ops;
    logic [16:0] mac_sum;
    logic [11:0] reading_sat;
    logic [11:0] smooth_new;

    // filter and pitch working registers
    logic [11:0] c_reg;
    logic [15:0] prev_reg;
    logic [5:0]  idx_reg;
    logic        idx_last;
    logic        cutoff_go;
    logic        key_go;
    logic [3:0]  key_idx;
    logic [11:0] note_f;
    logic [11:0] f_reg;
    logic [11:0] mag_reg;
    logic        neg_reg;
    logic [23:0] prod_reg;
    logic [12:0] bent_reg;
    logic [12:0] bent_calc;
    logic [12:0] bend_q_reg;
    logic [BEND_SHIFT+12:0] bend_full;

    // divider
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    div_status_t      div_stat;
    logic [DVD_W-1:0] div_quo;

    // output register
    logic        out_valid_reg;
    logic        out_load_entry;
    logic        out_load_timeout;
    logic        out_kind_reg;
    logic [5:0]  out_idx_reg;
    logic [15:0] out_filt_reg;
    logic [12:0] out_bent_reg;
    logic [24:0] out_period_reg;
    logic        out_last_reg;

    // ------------------------------------------------------------------------
    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == REG_GAIN) ? {20'b0, gain_reg} : 32'b0;

    // ------------------------------------------------------------------------
    // handshakes
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid & s_ready;
    assign slot_free = !out_valid_reg || m_ready;

    // ------------------------------------------------------------------------
    // control store: cutoff and pitch smoothing state, zero until first write
    assign ctrl_sel   = (mode_reg == MODE_PITCH) ? CTRL_PITCH : CTRL_CUTOFF;
    assign ctrl_raddr = (state_reg == S_IDLE) ?
                        ((s_mode == MODE_PITCH) ? CTRL_PITCH : CTRL_CUTOFF) : ctrl_sel;
    assign ctrl_we    = (state_reg == S_SM_DONE);
    assign ctrl_prev  = ctrl_valid_reg[ctrl_sel] ? ctrl_rdata : 12'd0;

    wcp_ram #(
        .WIDTH (12),
        .DEPTH (CTRL_DEPTH)
    ) u_ctrl_ram (
        .aclk  (aclk),
        .we    (ctrl_we),
        .waddr (ctrl_sel),
        .wdata (smooth_new),
        .raddr (ctrl_raddr),
        .rdata (ctrl_rdata)
    );

    // ------------------------------------------------------------------------
    // wave store
    assign wave_we    = s_accept && (s_mode == MODE_LOAD) &&
                        ({1'b0, s_wave_select} < 4'(WAVE_COUNT)) &&
                        ({1'b0, s_table_position} < 7'(TABLE_LEN));
    assign wave_waddr = store_addr(s_wave_select, s_table_position);
    // next entry is fetched while the current one is handed out
    assign rd_idx     = (state_reg == S_F_SUM) ? (idx_reg + 6'd1) : 6'd0;
    assign wave_raddr = store_addr(wsel_reg, rd_idx);

    wcp_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_wave_ram (
        .aclk  (aclk),
        .we    (wave_we),
        .waddr (wave_waddr),
        .wdata (s_sample_value),
        .raddr (wave_raddr),
        .rdata (wave_rdata)
    );

    // ------------------------------------------------------------------------
    // multiply and scale
    assign reading_sat = (sval_reg > 16'(ADC_FULL)) ? ADC_FULL : sval_reg[11:0];

    always_comb begin
        mac_ops.load = (state_reg == S_SM_OPS) || (state_reg == S_F_OPS);
        if (state_reg == S_F_OPS) begin
            mac_ops.a0 = wave_rdata;
            mac_ops.b0 = c_reg;
            mac_ops.a1 = prev_reg;
            mac_ops.b1 = ADC_FULL - c_reg;
        end else begin
            mac_ops.a0 = {4'b0, reading_sat};
            mac_ops.b0 = gain_reg;
            mac_ops.a1 = {4'b0, ctrl_prev};
            mac_ops.b1 = ADC_FULL - gain_reg;
        end
    end

    wcp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ops     (mac_ops),
        .sum     (mac_sum)
    );

    assign smooth_new = (mac_sum > 17'(ADC_FULL)) ? ADC_FULL : mac_sum[11:0];

    assign cutoff_go = (smooth_new > CUTOFF_MIN) && ({1'b0, wsel_reg} < 4'(WAVE_COUNT));
    assign key_go    = held_reg && (key_reg <= KEY_MAX);
    assign key_idx   = (key_reg <= KEY_MAX) ? key_reg : 4'd0;
    assign note_f    = NOTE_HZ[oct_reg][key_idx];
    assign idx_last  = (idx_reg == 6'(TABLE_LEN - 1));

    // ------------------------------------------------------------------------
    // bend scale: f*|p-mid| stays below 2^23, so the reciprocal product is exact
    assign bend_full = prod_reg * BEND_RECIP;

    // divider: sample period
    assign div_start    = (state_reg == S_PER_START);
    assign div_dividend = CLOCK_HZ;
    assign div_divisor  = DVS_W'(bent_reg * TABLE_LEN);

    wcp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_stat),
        .quotient (div_quo)
    );

    // truncation toward zero: divide the magnitude, then apply the sign
    always_comb begin
        if (neg_reg) begin
            if (bend_q_reg >= {1'b0, f_reg}) begin
                bent_calc = 13'd1;
            end else begin
                bent_calc = {1'b0, f_reg} - bend_q_reg;
            end
        end else begin
            bent_calc = {1'b0, f_reg} + bend_q_reg;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer
    assign out_load_entry   = (state_reg == S_F_SUM) && slot_free;
    assign out_load_timeout = (state_reg == S_EMIT) && slot_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept && (s_mode == MODE_CUTOFF || s_mode == MODE_PITCH)) begin
                    state_next = S_SM_OPS;
                end
            end
            S_SM_OPS:  state_next = S_SM_WAIT;
            S_SM_WAIT: state_next = S_SM_DONE;
            S_SM_DONE: begin
                if (mode_reg == MODE_CUTOFF) begin
                    state_next = cutoff_go ? S_F_OPS : S_IDLE;
                end else begin
                    state_next = key_go ? S_BEND_MUL : S_IDLE;
                end
            end
            S_F_OPS:  state_next = S_F_WAIT;
            S_F_WAIT: state_next = S_F_SUM;
            S_F_SUM: begin
                if (slot_free) begin
                    state_next = idx_last ? S_IDLE : S_F_OPS;
                end
            end
            S_BEND_MUL:   state_next = S_BEND_SCALE;
            S_BEND_SCALE: state_next = S_BEND_ADD;
            S_BEND_ADD:   state_next = S_PER_START;
            S_PER_START:  state_next = S_PER_DIV;
            S_PER_DIV: begin
                if (div_stat.done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            gain_reg       <= GAIN_RESET;
            ctrl_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_write && paddr[2] == REG_GAIN) begin
                gain_reg <= pwdata[11:0];
            end
            if (ctrl_we) begin
                ctrl_valid_reg[ctrl_sel] <= 1'b1;
            end
            if (out_load_entry || out_load_timeout) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_mode;
            sval_reg <= s_sample_value;
            wsel_reg <= s_wave_select;
            oct_reg  <= s_octave;
            key_reg  <= s_key_number;
            held_reg <= s_key_held;
        end
        case (state_reg)
            S_SM_DONE: begin
                c_reg    <= smooth_new;
                prev_reg <= 16'd0;
                idx_reg  <= 6'd0;
                f_reg    <= note_f;
                if (smooth_new >= PITCH_MID) begin
                    mag_reg <= smooth_new - PITCH_MID;
                    neg_reg <= 1'b0;
                end else begin
                    mag_reg <= PITCH_MID - smooth_new;
                    neg_reg <= 1'b1;
                end
            end
            S_F_SUM: begin
                if (slot_free) begin
                    prev_reg <= mac_sum[15:0];
                    idx_reg  <= idx_reg + 6'd1;
                end
            end
            S_BEND_MUL: begin
                prod_reg <= f_reg * mag_reg;
            end
            S_BEND_SCALE: begin
                bend_q_reg <= bend_full[BEND_SHIFT+12:BEND_SHIFT];
            end
            S_BEND_ADD: begin
                bent_reg <= bent_calc;
            end
            default: begin
            end
        endcase
        if (out_load_entry) begin
            out_kind_reg   <= KIND_ENTRY;
            out_idx_reg    <= idx_reg;
            out_filt_reg   <= mac_sum[15:0];
            out_bent_reg   <= 13'd0;
            out_period_reg <= 25'd0;
            out_last_reg   <= idx_last;
        end else if (out_load_timeout) begin
            out_kind_reg   <= KIND_TIMEOUT;
            out_idx_reg    <= 6'd0;
            out_filt_reg   <= 16'd0;
            out_bent_reg   <= bent_reg;
            out_period_reg <= div_quo;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_result_kind     = out_kind_reg;
    assign m_entry_index     = out_idx_reg;
    assign m_filtered_sample = out_filt_reg;
    assign m_bent_frequency  = out_bent_reg;
    assign m_period_timeout  = out_period_reg;
    assign m_last_of_run     = out_last_reg;

    // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
    ap_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    ap_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("request taken while divider busy");

    ap_last_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_ENTRY && m_last_of_run)
            |-> (m_entry_index == 6'(TABLE_LEN - 1)))
        else $error("run ended before the table end");

    ap_timeout_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == KIND_TIMEOUT)
            |-> (m_bent_frequency != 13'd0 && m_last_of_run))
        else $error("bad sample period result");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wavetable cutoff and pitch control block. A
// queue of requests feeds a valid/ready driver; each accepted request is run
// through a local predictor of the smoothing, table lowpass and pitch-bend
// arithmetic, and a monitor compares every result with the oldest prediction.
// The smoothing gain is swept over several settings between quiet phases.
// ----------------------------------------------------------------------------

module testbench;
    import wcp_pkg::*;

    localparam int          FULL_SCALE    = 4095;
    localparam int          BEND_CENTRE   = 2048;
    localparam int          BEND_SPAN     = 8195;
    localparam int          SAMPLE_CLOCK  = 25000000;
    localparam int          CUTOFF_FLOOR  = 5;
    localparam int          KEY_TOP       = 12;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam logic [2:0]  GAIN_ADDR     = 3'd0;
    localparam int          SETTLE_CYCLES = 250;
    localparam int          HOLD_CYCLES   = 400;

    localparam int NOTE_FREQ [8][13] = '{
        '{16, 17, 18, 19, 21, 22, 23, 24, 26, 27, 29, 31, 33},
        '{33, 35, 37, 39, 41, 44, 46, 49, 52, 55, 58, 62, 65},
        '{65, 69, 73, 78, 82, 87, 92, 98, 104, 110, 117, 123, 131},
        '{131, 139, 147, 156, 167, 175, 185, 196, 208, 220, 233, 247, 262},
        '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494, 523},
        '{523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988, 1046},
        '{1046, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976, 2093},
        '{2093, 2218, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3900, 3900}
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] sample_value;
        logic [2:0]  wave_select;
        logic [5:0]  table_position;
        logic [2:0]  octave;
        logic [3:0]  key_number;
        logic        key_held;
    } control_req_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  index;
        logic [15:0] sample;
        logic [12:0] freq;
        logic [24:0] period;
        logic        last;
    } control_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [15:0] s_sample_value = '0;
    logic [2:0]  s_wave_select = '0;
    logic [5:0]  s_table_position = '0;
    logic [2:0]  s_octave = '0;
    logic [3:0]  s_key_number = '0;
    logic        s_key_held = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_result_kind;
    logic [5:0]  m_entry_index;
    logic [15:0] m_filtered_sample;
    logic [12:0] m_bent_frequency;
    logic [24:0] m_period_timeout;
    logic        m_last_of_run;

    wavetable_cutoff_and_pitch_control_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_sample_value    (s_sample_value),
        .s_wave_select     (s_wave_select),
        .s_table_position  (s_table_position),
        .s_octave          (s_octave),
        .s_key_number      (s_key_number),
        .s_key_held        (s_key_held),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_entry_index     (m_entry_index),
        .m_filtered_sample (m_filtered_sample),
        .m_bent_frequency  (m_bent_frequency),
        .m_period_timeout  (m_period_timeout),
        .m_last_of_run     (m_last_of_run)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [11:0]     gain_setting = 12'd1000;
    logic [11:0]     cutoff_level = '0;
    logic [11:0]     pitch_level = '0;
    logic [15:0]     wave_mem [WAVE_COUNT*TABLE_LEN];
    control_result_t due_results [$];

    // request generation
    control_req_t    queued_requests [$];
    control_req_t    held_req;
    bit              loaded [WAVE_COUNT*TABLE_LEN];
    logic [11:0]     gen_cutoff = '0;

    int queued_count = 0;
    int accepted_count = 0;
    int checked_count = 0;
    int filter_runs = 0;
    int timeout_results = 0;
    int fail_count = 0;
    bit no_gaps = 1'b0;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;

    function automatic logic [11:0] smooth_reading(input logic [15:0] reading,
                                                   input logic [11:0] prev,
                                                   input logic [11:0] gain);
        int unsigned r;
        int unsigned s;
        r = (reading > FULL_SCALE) ? FULL_SCALE : reading;
        s = (r * gain) / FULL_SCALE + (prev * (FULL_SCALE - gain)) / FULL_SCALE;
        if (s > FULL_SCALE) begin
            s = FULL_SCALE;
        end
        return 12'(s);
    endfunction

    task automatic run_control(input control_req_t r);
        control_result_t res;
        int unsigned     x;
        int unsigned     y;
        int unsigned     trail;
        int unsigned     c;
        int              f;
        int              bent;
        case (r.mode)
            MODE_LOAD: begin
                if (r.wave_select < WAVE_COUNT && r.table_position < TABLE_LEN) begin
                    wave_mem[int'(r.wave_select) * TABLE_LEN + int'(r.table_position)] =
                        r.sample_value;
                end
            end
            MODE_CUTOFF: begin
                cutoff_level = smooth_reading(r.sample_value, cutoff_level, gain_setting);
                if (cutoff_level > CUTOFF_FLOOR && r.wave_select < WAVE_COUNT) begin
                    c = cutoff_level;
                    trail = 0;
                    filter_runs++;
                    for (int i = 0; i < TABLE_LEN; i++) begin
                        x = wave_mem[int'(r.wave_select) * TABLE_LEN + i];
                        y = (x * c) / FULL_SCALE + (trail * (FULL_SCALE - c)) / FULL_SCALE;
                        y = y & 32'hFFFF;
                        trail = y;
                        res = '0;
                        res.kind = KIND_ENTRY;
                        res.index = 6'(i);
                        res.sample = 16'(y);
                        res.last = (i == TABLE_LEN - 1);
                        due_results.push_back(res);
                    end
                end
            end
            MODE_PITCH: begin
                pitch_level = smooth_reading(r.sample_value, pitch_level, gain_setting);
                if (r.key_held && r.key_number <= KEY_TOP) begin
                    f = NOTE_FREQ[r.octave][r.key_number];
                    // signed bend, division truncates toward zero
                    bent = f + (f * (int'(pitch_level) - BEND_CENTRE)) / BEND_SPAN;
                    if (bent < 1) begin
                        bent = 1;
                    end
                    res = '0;
                    res.kind = KIND_TIMEOUT;
                    res.freq = 13'(bent);
                    res.period = 25'(SAMPLE_CLOCK / (bent * TABLE_LEN));
                    res.last = 1'b1;
                    due_results.push_back(res);
                    timeout_results++;
                end
            end
            default: begin
            end
        endcase
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                run_control(held_req);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (queued_requests.size() != 0 && (no_gaps || $urandom_range(99) >= 7)) begin
                    held_req = queued_requests.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= held_req.mode;
                    s_sample_value <= held_req.sample_value;
                    s_wave_select <= held_req.wave_select;
                    s_table_position <= held_req.table_position;
                    s_octave <= held_req.octave;
                    s_key_number <= held_req.key_number;
                    s_key_held <= held_req.key_held;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endtask

    // result monitor
    always @(posedge aclk) begin
        control_result_t seen;
        control_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen = {m_result_kind, m_entry_index, m_filtered_sample, m_bent_frequency,
                        m_period_timeout, m_last_of_run};
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d index %0d sample %0d", seen.kind,
                           seen.index, seen.sample);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", want.kind, seen.kind);
                    check_field("entry_index", want.index, seen.index);
                    check_field("filtered_sample", want.sample, seen.sample);
                    check_field("bent_frequency", want.freq, seen.freq);
                    check_field("period_timeout", want.period, seen.period);
                    check_field("last_of_run", want.last, seen.last);
                    checked_count++;
                end
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
            end else if (hold_asks != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            m_ready <= (hold_left == 0) && (no_gaps || $urandom_range(99) >= 7);
        end
    end

    function automatic bit table_full(input int w);
        for (int p = 0; p < TABLE_LEN; p++) begin
            if (!loaded[w * TABLE_LEN + p]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [2:0] loaded_table();
        int fulls [$];
        for (int w = 0; w < WAVE_COUNT; w++) begin
            if (table_full(w)) begin
                fulls.push_back(w);
            end
        end
        if (fulls.size() == 0) begin
            return 3'd0;
        end
        return 3'(fulls[$urandom_range(fulls.size() - 1)]);
    endfunction

    function automatic logic [15:0] adc_reading();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'(FULL_SCALE);
            2: return 16'hFFFF;
            3, 4, 5: return 16'($urandom_range(FULL_SCALE));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic queue_request(input control_req_t r);
        logic [11:0] next_cutoff;
        if (r.mode == MODE_CUTOFF) begin
            next_cutoff = smooth_reading(r.sample_value, gen_cutoff, gain_setting);
            // a filter pass over a partly loaded table would read unwritten samples
            if (next_cutoff > CUTOFF_FLOOR && r.wave_select < WAVE_COUNT &&
                !table_full(r.wave_select)) begin
                r.wave_select = 3'($urandom_range(7, WAVE_COUNT));
            end
            gen_cutoff = next_cutoff;
        end else if (r.mode == MODE_LOAD && r.wave_select < WAVE_COUNT &&
                     r.table_position < TABLE_LEN) begin
            loaded[int'(r.wave_select) * TABLE_LEN + int'(r.table_position)] = 1'b1;
        end
        queued_requests.push_back(r);
        queued_count++;
    endtask

    task automatic queue_fields(input logic [1:0] mode, input logic [15:0] value,
                                input logic [2:0] wsel, input logic [5:0] pos,
                                input logic [2:0] oct, input logic [3:0] key,
                                input logic held);
        queue_request('{mode, value, wsel, pos, oct, key, held});
    endtask

    task automatic queue_table_load(input logic [2:0] wsel);
        logic [15:0] value;
        for (int p = 0; p < TABLE_LEN; p++) begin
            case ($urandom_range(7))
                0: value = 16'h0000;
                1: value = 16'hFFFF;
                default: value = 16'($urandom_range(65535));
            endcase
            queue_fields(MODE_LOAD, value, wsel, 6'(p), 3'($urandom_range(7)),
                         4'($urandom_range(15)), 1'($urandom_range(1)));
        end
    endtask

    task automatic queue_random_request();
        control_req_t r;
        int           pick;
        r.mode = MODE_LOAD;
        r.sample_value = 16'($urandom_range(65535));
        r.wave_select = 3'($urandom_range(7));
        r.table_position = 6'($urandom_range(63));
        r.octave = 3'($urandom_range(7));
        r.key_number = 4'($urandom_range(15));
        r.key_held = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 30) begin
            r.mode = MODE_CUTOFF;
            r.sample_value = adc_reading();
            if ($urandom_range(3) != 0) begin
                r.wave_select = loaded_table();
            end
        end else if (pick < 62) begin
            r.mode = MODE_PITCH;
            r.sample_value = adc_reading();
            if ($urandom_range(9) != 0) begin
                r.key_held = 1'b1;
                r.key_number = 4'($urandom_range(KEY_TOP));
            end
        end else if (pick >= 92) begin
            r.mode = MODE_UNUSED;
        end
        queue_request(r);
    endtask

    task automatic queue_random_burst(input int count);
        repeat (count) begin
            queue_random_request();
        end
    endtask

    task automatic wait_for_quiet();
        do begin
            @(posedge aclk);
        end while (accepted_count != queued_count || due_results.size() != 0);
        // an item without results may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [11:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= GAIN_ADDR;
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gain_setting = value;
    endtask

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // nothing loaded yet: ignored and empty-handed requests and pitch results, then table 0 is loaded and filtered
        queue_fields(MODE_UNUSED, 16'hFFFF, 3'd7, 6'd63, 3'd7, 4'd15, 1'b1);
        queue_fields(MODE_LOAD, 16'hFFFF, 3'd4, 6'd0, 3'd0, 4'd0, 1'b0);
        queue_fields(MODE_LOAD, 16'h1234, 3'd7, 6'd63, 3'd0, 4'd0, 1'b0);
        queue_fields(MODE_PITCH, 16'hFFFF, 3'd4, 6'd0, 3'd4, 4'd9, 1'b0);
        queue_fields(MODE_PITCH, 16'd2048, 3'd0, 6'd0, 3'd3, 4'd13, 1'b1);
        queue_fields(MODE_PITCH, 16'd2048, 3'd0, 6'd0, 3'd3, 4'd15, 1'b1);
        queue_fields(MODE_PITCH, 16'd0, 3'd0, 6'd0, 3'd0, 4'd0, 1'b1);
        queue_fields(MODE_PITCH, 16'd4095, 3'd0, 6'd0, 3'd7, 4'd12, 1'b1);
        queue_fields(MODE_PITCH, 16'hFFFF, 3'd0, 6'd0, 3'd3, 4'd5, 1'b1);
        queue_fields(MODE_CUTOFF, 16'd4095, 3'd7, 6'd0, 3'd0, 4'd0, 1'b0);
        queue_fields(MODE_CUTOFF, 16'hFFFF, 3'd4, 6'd0, 3'd0, 4'd0, 1'b0);
        queue_table_load(3'd0);
        queue_fields(MODE_CUTOFF, 16'd4095, 3'd0, 6'd0, 3'd0, 4'd0, 1'b0);
        queue_random_burst(16);
        wait_for_quiet();

        // full gain: smoothed value follows the reading exactly
        write_gain(12'd4095);
        queue_fields(MODE_CUTOFF, 16'd5, 3'd0, 6'd0, 3'd0, 4'd0, 1'b0);
        queue_fields(MODE_CUTOFF, 16'd6, 3'd0, 6'd0, 3'd0, 4'd0, 1'b0);
        queue_fields(MODE_CUTOFF, 16'hFFFF, 3'd0, 6'd0, 3'd0, 4'd0, 1'b0);
        queue_fields(MODE_PITCH, 16'd0, 3'd0, 6'd0, 3'd0, 4'd0, 1'b1);
        queue_fields(MODE_PITCH, 16'd4095, 3'd0, 6'd0, 3'd7, 4'd12, 1'b1);
        queue_fields(MODE_PITCH, 16'd2048, 3'd0, 6'd0, 3'd4, 4'd9, 1'b1);
        queue_table_load(3'd3);
        queue_random_burst(16);
        wait_for_quiet();

        // zero gain freezes both controls
        write_gain(12'd0);
        queue_random_burst(12);
        wait_for_quiet();

        // no idling on either side, one long output stall to back up the input
        write_gain(12'($urandom_range(4094, 2)));
        no_gaps = 1'b1;
        hold_asks++;
        queue_random_burst(36);
        wait_for_quiet();
        no_gaps = 1'b0;

        write_gain(12'd1);
        queue_random_burst(16);
        wait_for_quiet();

        $display("tb: %0d requests accepted, %0d results checked (%0d table passes, %0d periods)",
                 accepted_count, checked_count, filter_runs, timeout_results);
        $display("tb: gain swept over reset, full scale, zero, mid and one, with a forced stall");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
